// ===== hdl/cta_pkg.sv =====
// Shared constants, types and helpers for the counted tape machine datapath.
// No dependencies; used by counted_tape_machine_datapath.
`timescale 1ns / 1ps

package cta_pkg;

    localparam int TAPE_DEPTH = 32768;
    localparam int TAPE_AW    = $clog2(TAPE_DEPTH);
    localparam int HOME_W     = 15;
    localparam int AMT_W      = 16;
    localparam int CELL_W     = 8;
    localparam int OP_W       = 3;
    // wide enough for head and amount compares without overflow
    localparam int CMP_W      = ((TAPE_AW > AMT_W) ? TAPE_AW : AMT_W) + 1;

    typedef logic [TAPE_AW-1:0] t_addr;
    typedef logic [CMP_W-1:0]   t_cmp;
    typedef logic [CELL_W-1:0]  t_cell;
    typedef logic [HOME_W-1:0]  t_home;

    localparam t_addr TAPE_LAST  = t_addr'(TAPE_DEPTH - 1);
    localparam t_home HOME_RESET = t_home'(16384);

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_SUB    = 3'd1,
        OP_MOVE_R = 3'd2,
        OP_MOVE_L = 3'd3,
        OP_ZTEST  = 3'd4,
        OP_OUTPUT = 3'd5,
        OP_INPUT  = 3'd6
    } t_op;

    // Head position for a home value; a home past the tape sits on the last cell.
    function automatic t_addr clamp_home(input t_home pos);
        t_addr res;
        if (t_cmp'(pos) > t_cmp'(TAPE_LAST)) begin
            res = TAPE_LAST;
        end else begin
            res = t_addr'(pos);
        end
        return res;
    endfunction

endpackage

// ===== hdl/counted_tape_machine_datapath.sv =====
// Top level of the counted tape machine datapath: head logic, tape memory,
// cell update stage and result register. Depends on cta_pkg.
`timescale 1ns / 1ps

// One operation is accepted per clock whenever busy is low, and its result
// appears with o_res_strobe after the update stage and result registers, in
// order, one result per operation. The receiver cannot stall, so results are
// never held. The head moves in the accept cycle and the tape memory is read
// there with a registered read; the next cycle updates the cell, writes it
// back and forwards it to the following operation. After reset busy stays
// high while a clearing pass zeroes the tape one cell a cycle; configuration
// writes are taken at any time and move the head home.
module counted_tape_machine_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [cta_pkg::OP_W-1:0]    i_operation,
    input  logic [cta_pkg::AMT_W-1:0]   i_amount,
    input  logic [cta_pkg::CELL_W-1:0]  i_in_byte,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [cta_pkg::HOME_W-1:0]  i_cfg_data,
    output logic                        o_res_strobe,
    output logic [cta_pkg::CELL_W-1:0]  o_out_byte,
    output logic                        o_out_valid,
    output logic                        o_cell_is_zero,
    output logic                        o_edge_error
);

    // tape memory and clearing pass
    cta_pkg::t_cell r_tape [cta_pkg::TAPE_DEPTH];
    cta_pkg::t_cell r_rd_data;
    logic           r_clr_busy;
    cta_pkg::t_addr r_clr_addr;

    // head
    cta_pkg::t_addr r_head;
    cta_pkg::t_addr n_head;
    logic           a_edge;
    logic           accept;
    logic           cfg_wr;
    cta_pkg::t_op   a_op;
    cta_pkg::t_cmp  amt_c;
    cta_pkg::t_cmp  head_c;
    cta_pkg::t_cmp  room_c;

    // update stage
    logic           r_b_vld;
    cta_pkg::t_op   r_b_op;
    cta_pkg::t_addr r_b_head;
    cta_pkg::t_cell r_b_amt;
    cta_pkg::t_cell r_b_byte;
    logic           r_b_edge;
    cta_pkg::t_cell b_cell_old;
    cta_pkg::t_cell n_cell;
    logic           b_we;

    // results and forwarding
    logic           r_strobe;
    cta_pkg::t_cell r_out_byte;
    logic           r_out_valid;
    logic           r_zero;
    logic           r_edge;
    logic           r_prev_vld;
    cta_pkg::t_addr r_prev_head;

    logic           mem_we;
    cta_pkg::t_addr mem_wa;
    cta_pkg::t_cell mem_wd;

    assign busy        = r_clr_busy;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign a_op        = cta_pkg::t_op'(i_operation);

    // head move and clamp
    always_comb begin
        amt_c  = cta_pkg::t_cmp'(i_amount);
        head_c = cta_pkg::t_cmp'(r_head);
        room_c = cta_pkg::t_cmp'(cta_pkg::TAPE_LAST) - head_c;
        n_head = r_head;
        a_edge = 1'b0;
        if (cfg_wr) begin
            n_head = cta_pkg::clamp_home(i_cfg_data);
        end else if (accept) begin
            case (a_op)
                cta_pkg::OP_MOVE_R: begin
                    if (amt_c > room_c) begin
                        n_head = cta_pkg::TAPE_LAST;
                        a_edge = 1'b1;
                    end else begin
                        n_head = cta_pkg::t_addr'(head_c + amt_c);
                    end
                end
                cta_pkg::OP_MOVE_L: begin
                    if (amt_c > head_c) begin
                        n_head = '0;
                        a_edge = 1'b1;
                    end else begin
                        n_head = cta_pkg::t_addr'(head_c - amt_c);
                    end
                end
                default: begin
                    n_head = r_head;
                end
            endcase
        end
    end

    // cell update; take the previous result when it sits on the same cell
    always_comb begin
        if (r_prev_vld && (r_prev_head == r_b_head)) begin
            b_cell_old = r_out_byte;
        end else begin
            b_cell_old = r_rd_data;
        end
        n_cell = b_cell_old;
        b_we   = 1'b0;
        case (r_b_op)
            cta_pkg::OP_ADD: begin
                n_cell = b_cell_old + r_b_amt;
                b_we   = r_b_vld;
            end
            cta_pkg::OP_SUB: begin
                n_cell = b_cell_old - r_b_amt;
                b_we   = r_b_vld;
            end
            cta_pkg::OP_INPUT: begin
                n_cell = r_b_byte;
                b_we   = r_b_vld;
            end
            default: begin
                n_cell = b_cell_old;
            end
        endcase
    end

    assign mem_we = r_clr_busy || b_we;
    assign mem_wa = r_clr_busy ? r_clr_addr : r_b_head;
    assign mem_wd = r_clr_busy ? '0 : n_cell;

    // read-first: a same-cycle write is covered by the forwarding path
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tape[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_tape[n_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_head      <= cta_pkg::clamp_home(cta_pkg::HOME_RESET);
            r_b_vld     <= 1'b0;
            r_strobe    <= 1'b0;
            r_prev_vld  <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == cta_pkg::TAPE_LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_head   <= n_head;
            r_b_vld  <= accept;
            r_strobe <= r_b_vld;
            if (r_b_vld) begin
                r_prev_vld <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_op   <= a_op;
            r_b_head <= n_head;
            r_b_amt  <= i_amount[cta_pkg::CELL_W-1:0];
            r_b_byte <= i_in_byte;
            r_b_edge <= a_edge;
        end
        if (r_b_vld) begin
            r_out_byte  <= n_cell;
            r_out_valid <= (r_b_op == cta_pkg::OP_OUTPUT);
            r_zero      <= (n_cell == '0);
            r_edge      <= r_b_edge;
            r_prev_head <= r_b_head;
        end
    end

    assign o_res_strobe   = r_strobe;
    assign o_out_byte     = r_out_byte;
    assign o_out_valid    = r_out_valid;
    assign o_cell_is_zero = r_zero;
    assign o_edge_error   = r_edge;

    // no operation may be in flight while the tape is being cleared
    a_no_work_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!r_b_vld && !r_strobe))
        else $error("operation in flight during tape clear");

    // every result comes from an operation in the update stage on the previous cycle
    a_strobe_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_b_vld))
        else $error("result strobe without an operation");

    // an accepted operation reaches the update stage next cycle
    a_accept_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_b_vld)
        else $error("accepted operation lost");

    // head never leaves the tape
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= cta_pkg::TAPE_LAST)
        else $error("head beyond tape end");

endmodule
